[rtl/sorted_list_insert_delete_unit_defines.svh]
// Assertion macros for the sorted list unit.
// Used by sli_ctrl and sli_dp; expects clk and arst_n in scope.
`ifndef SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH
`define SORTED_LIST_INSERT_DELETE_UNIT_DEFINES_SVH

// same-cycle implication, masked while in reset
`define SLI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, masked while in reset
`define SLI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/sli_pkg.sv]
// Shared types and codes for the sorted list insert/delete unit.
// No dependencies.
`default_nettype none

package sli_pkg;

	localparam int KIND_W  = 3;
	localparam int STAT_W  = 3;
	localparam int IOVAL_W = 32;
	localparam int OCC_W   = 6;

	// item kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 3'd0,
		KIND_DELETE = 3'd1,
		KIND_CLEAR  = 3'd2,
		KIND_COUNT  = 3'd3,
		KIND_READ   = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		STAT_DONE     = 3'd0,
		STAT_FULL     = 3'd1,
		STAT_NOTFOUND = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_ELEM     = 3'd4
	} status_t;

	// input beat
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [IOVAL_W-1:0] value;
	} item_t;

	// result beat
	typedef struct packed {
		logic [STAT_W-1:0]         status;
		logic signed [IOVAL_W-1:0] entry_value;
		logic [OCC_W-1:0]          occupancy;
		logic                      last;
	} result_t;

	// datapath operations
	typedef enum logic [2:0] {
		DP_NONE,
		DP_INSERT,
		DP_DELETE,
		DP_CLEAR,
		DP_REPORT,
		DP_READ
	} dp_op_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		dp_op_t  op;
		status_t status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic found;
		logic rd_last;
	} dp_sts_t;

endpackage

`default_nettype wire

[rtl/sorted_list_insert_delete_unit.sv]
// Top level of the sorted list insert/delete unit.
// Instantiates sli_ctrl and sli_dp; depends on sli_pkg.
//
//   port group      dir  handshake              payload
//   start/item      in   start && !busy         item_t   (kind, value)
//   result_strobe   out  one-cycle strobe       result_t (status, entry_value, occupancy, last)
//
// For each item the accept edge captures the key and the compare vector against all cells,
// and the next edge shifts the cell chain and registers the result.
// Readout gives one result beat per entry, taken from the read pointer.
// Reset clears the entry count and control; cells are not reset, and unwritten cells never reach a result.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
`default_nettype none

module sorted_list_insert_delete_unit #(
	parameter int CAPACITY    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire sli_pkg::item_t    item,
	output logic                   busy,
	output logic                   result_strobe,
	output sli_pkg::result_t       result
);
	import sli_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	sli_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (item.kind),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	sli_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_value      (item.value),
		.cmd           (cmd),
		.sts           (sts),
		.result_strobe (result_strobe),
		.result        (result)
	);

endmodule

`default_nettype wire

[rtl/sli_ctrl.sv]
// Controller FSM for the sorted list unit: sequences capture, execute, readout.
// Depends on sli_pkg and sorted_list_insert_delete_unit_defines.svh.
`default_nettype none
`include "sorted_list_insert_delete_unit_defines.svh"

module sli_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [sli_pkg::KIND_W-1:0]    kind,
	input  wire sli_pkg::dp_sts_t              sts,
	output sli_pkg::dp_cmd_t                   cmd,
	output logic                               busy
);
	import sli_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ
	} state_t;

	state_t              state_q;
	logic [KIND_W-1:0]   kind_q;
	logic                busy_q;

	assign busy = busy_q;

	// command decode from state, latched kind, start and datapath status
	always_comb begin
		cmd = '{capture: 1'b0, op: DP_NONE, status: STAT_DONE};
		unique case (state_q)
			S_IDLE: begin
				cmd.capture = start;
			end
			S_EXEC: begin
				case (kind_q)
					KIND_INSERT: begin
						if (sts.full) begin
							cmd.op     = DP_REPORT;
							cmd.status = STAT_FULL;
						end else begin
							cmd.op = DP_INSERT;
						end
					end
					KIND_DELETE: begin
						if (sts.found) begin
							cmd.op = DP_DELETE;
						end else begin
							cmd.op     = DP_REPORT;
							cmd.status = STAT_NOTFOUND;
						end
					end
					KIND_CLEAR: begin
						cmd.op = DP_CLEAR;
					end
					KIND_READ: begin
						if (sts.empty) begin
							cmd.op     = DP_REPORT;
							cmd.status = STAT_EMPTY;
						end else begin
							cmd.op     = DP_READ;
							cmd.status = STAT_ELEM;
						end
					end
					default: begin
						cmd.op = DP_REPORT;
					end
				endcase
			end
			S_READ: begin
				cmd.op     = DP_READ;
				cmd.status = STAT_ELEM;
			end
			default: begin
				cmd.op = DP_NONE;
			end
		endcase
	end

	// state, latched kind and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			kind_q  <= '0;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
						kind_q  <= kind;
						busy_q  <= 1'b1;
					end
				end
				S_EXEC: begin
					if (kind_q == KIND_READ && !sts.empty && !sts.rd_last) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				S_READ: begin
					if (sts.rd_last) begin
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	`SLI_ASSERT_NOW(a_busy_tracks_state, 1'b1, busy_q == (state_q != S_IDLE), "busy out of step with state")
	`SLI_ASSERT_NOW(a_read_only_readout, state_q == S_READ, kind_q == KIND_READ, "readout state for other kind")
	`SLI_ASSERT_NEXT(a_accept_enters_exec, state_q == S_IDLE && start, state_q == S_EXEC, "accepted beat not executed")

endmodule

`default_nettype wire

[rtl/sli_dp.sv]
// Datapath for the sorted list unit: cell chain of entries, compare vector,
// entry count, readout pointer and result register. Depends on sli_pkg and the defines header.
`default_nettype none
`include "sorted_list_insert_delete_unit_defines.svh"

module sli_dp #(
	parameter int CAPACITY    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic signed [sli_pkg::IOVAL_W-1:0] in_value,
	input  wire sli_pkg::dp_cmd_t              cmd,
	output sli_pkg::dp_sts_t                   sts,
	output logic                               result_strobe,
	output sli_pkg::result_t                   result
);
	import sli_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);

	// entry cells, no reset: only the first cnt_q are ever looked at
	logic signed [VALUE_WIDTH-1:0] cells_q [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic [CAPACITY-1:0]           lt_q;
	logic                          found_q;
	logic [CW-1:0]                 cnt_q;
	logic [CW-1:0]                 cnt_next;
	logic [IW-1:0]                 rd_idx_q;
	logic                          rd_last;
	logic                          strobe_q;
	result_t                       res_q;

	logic signed [63:0]            in_ext;
	logic signed [VALUE_WIDTH-1:0] in_key;
	logic [CAPACITY-1:0]           lt_now;
	logic [CAPACITY-1:0]           eq_now;
	logic signed [VALUE_WIDTH-1:0] rd_val;
	logic signed [63:0]            rd_ext;

	// input value as a stored key
	assign in_ext = 64'(in_value);
	assign in_key = in_ext[VALUE_WIDTH-1:0];

	// parallel compare against every occupied cell
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			lt_now[i] = (CW'(i) < cnt_q) && (cells_q[i] < in_key);
			eq_now[i] = (CW'(i) < cnt_q) && (cells_q[i] == in_key);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			key_q   <= in_key;
			lt_q    <= lt_now;
			found_q <= |eq_now;
		end
	end

	// cell chain: insert shifts up from the slot, delete shifts down into it
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		always_ff @(posedge clk) begin
			if (cmd.op == DP_INSERT && !lt_q[g]) begin
				if (g == 0) begin
					cells_q[g] <= key_q;
				end else if (lt_q[(g == 0) ? 0 : g-1]) begin
					cells_q[g] <= key_q;
				end else begin
					cells_q[g] <= cells_q[(g == 0) ? 0 : g-1];
				end
			end else if (cmd.op == DP_DELETE && !lt_q[g] && g < CAPACITY-1) begin
				cells_q[g] <= cells_q[(g < CAPACITY-1) ? g+1 : g];
			end
		end
	end

	// entry count
	always_comb begin
		case (cmd.op)
			DP_INSERT: cnt_next = cnt_q + CW'(1);
			DP_DELETE: cnt_next = cnt_q - CW'(1);
			DP_CLEAR:  cnt_next = '0;
			default:   cnt_next = cnt_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_next;
		end
	end

	// readout pointer
	assign rd_last = (CW'(rd_idx_q) + CW'(1)) == cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.capture) begin
			rd_idx_q <= '0;
		end else if (cmd.op == DP_READ) begin
			rd_idx_q <= rd_idx_q + IW'(1);
		end
	end

	assign rd_val = cells_q[rd_idx_q];
	assign rd_ext = 64'(rd_val);

	// result register: one beat per operation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (cmd.op != DP_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op != DP_NONE) begin
			res_q.status      <= cmd.status;
			res_q.occupancy   <= OCC_W'(cnt_next);
			if (cmd.op == DP_READ) begin
				res_q.entry_value <= rd_ext[IOVAL_W-1:0];
				res_q.last        <= rd_last;
			end else begin
				res_q.entry_value <= '0;
				res_q.last        <= 1'b1;
			end
		end
	end

	assign result_strobe = strobe_q;
	assign result        = res_q;

	assign sts.full    = (cnt_q == CW'(CAPACITY));
	assign sts.empty   = (cnt_q == '0);
	assign sts.found   = found_q;
	assign sts.rd_last = rd_last;

	`SLI_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY), "entry count above capacity")
	`SLI_ASSERT_NOW(a_no_insert_full, cmd.op == DP_INSERT, cnt_q != CW'(CAPACITY), "insert into full store")
	`SLI_ASSERT_NOW(a_read_in_range, cmd.op == DP_READ, CW'(rd_idx_q) < cnt_q, "readout past last entry")

endmodule

`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for sorted_list_insert_delete_unit: directed table, then random episodes.
// Depends on sli_pkg and the unit's RTL; a shadow sorted list predicts every beat the table does not type in.
module tb;
	import sli_pkg::*;

	localparam int CAPACITY     = 32;
	localparam int RANDOM_ITEMS = 250;
	localparam int TAIL_ITEMS   = 40;    // no idling over the last items
	localparam int STALL_LIMIT  = 2000;  // cycles with no beat either way
	localparam int DRAIN_CYCLES = 40;    // longest readout plus margin

	// kinds the unit only reports as done, with no change to the list
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	typedef result_t result_q_t[$];

	// directed row: expected beat typed in only when typed is set
	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic signed [IOVAL_W-1:0] value;
		logic                      typed;
		status_t                   st;
		logic [OCC_W-1:0]          occ;
	} row_t;

	localparam int DIRECTED_N = 19;
	localparam row_t DIRECTED [DIRECTED_N] = '{
		'{KIND_COUNT,       32'sh0000_0000, 1'b1, STAT_DONE,     6'd0},
		'{KIND_READ,        32'sh1234_5678, 1'b1, STAT_EMPTY,    6'd0},
		'{KIND_DELETE,      32'sh0000_0005, 1'b1, STAT_NOTFOUND, 6'd0},
		'{KIND_SPARE_FIRST, 32'shFFFF_FFFF, 1'b1, STAT_DONE,     6'd0},
		'{KIND_SPARE_LAST,  32'sh7FFF_FFFF, 1'b1, STAT_DONE,     6'd0},
		'{KIND_INSERT,      32'sh7FFF_FFFF, 1'b1, STAT_DONE,     6'd1},
		'{KIND_INSERT,      32'sh8000_0000, 1'b1, STAT_DONE,     6'd2},
		'{KIND_INSERT,      32'sh0000_0000, 1'b1, STAT_DONE,     6'd3},
		'{KIND_INSERT,      32'shFFFF_FFFF, 1'b1, STAT_DONE,     6'd4},
		'{KIND_INSERT,      32'sh0000_0000, 1'b1, STAT_DONE,     6'd5},
		'{KIND_COUNT,       32'shDEAD_BEEF, 1'b1, STAT_DONE,     6'd5},
		'{KIND_READ,        32'sh0000_0000, 1'b0, STAT_DONE,     6'd0},
		'{KIND_DELETE,      32'sh0000_0000, 1'b1, STAT_DONE,     6'd4},
		'{KIND_DELETE,      32'sh0000_3039, 1'b1, STAT_NOTFOUND, 6'd4},
		'{KIND_DELETE,      32'sh8000_0000, 1'b1, STAT_DONE,     6'd3},
		'{KIND_READ,        32'shFFFF_FFFF, 1'b0, STAT_DONE,     6'd0},
		'{KIND_CLEAR,       32'sh5555_5555, 1'b1, STAT_DONE,     6'd0},
		'{KIND_INSERT,      32'shAAAA_AAAA, 1'b1, STAT_DONE,     6'd1},
		'{KIND_READ,        32'sh0000_0000, 1'b0, STAT_DONE,     6'd0}
	};

	logic    clk    = 1'b0;
	logic    arst_n = 1'b0;
	logic    start  = 1'b0;
	item_t   item   = '0;
	logic    busy;
	logic    result_strobe;
	result_t result;

	// shadow of the unit's list, ascending
	logic signed [IOVAL_W-1:0] sorted_entries[$];
	result_t pending_beats[$];
	result_t want;
	int      items_accepted = 0;
	int      beat_no        = 0;
	int      mismatches     = 0;
	int      idle_cycles    = 0;
	bit      idle_on        = 1'b1;

	sorted_list_insert_delete_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.item         (item),
		.busy         (busy),
		.result_strobe(result_strobe),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 50)
			$display("MISMATCH @%0t: %s", $realtime, msg);
	endtask

	function automatic result_t make_beat(status_t st, logic signed [IOVAL_W-1:0] v,
			logic fin);
		result_t r;
		r.status      = st;
		r.entry_value = v;
		r.occupancy   = OCC_W'(sorted_entries.size());
		r.last        = fin;
		return r;
	endfunction

	// apply one item to the shadow list and return the beats it causes
	task automatic compute_list_results(input item_t it, output result_q_t beats);
		logic signed [IOVAL_W-1:0] v;
		int pos;
		beats = {};
		v = it.value;
		case (it.kind)
			KIND_INSERT: begin
				if (sorted_entries.size() >= CAPACITY) begin
					beats.push_back(make_beat(STAT_FULL, '0, 1'b1));
				end else begin
					// goes ahead of any equal entries
					pos = 0;
					while (pos < sorted_entries.size() && sorted_entries[pos] < v)
						pos++;
					sorted_entries.insert(pos, v);
					beats.push_back(make_beat(STAT_DONE, '0, 1'b1));
				end
			end
			KIND_DELETE: begin
				pos = -1;
				foreach (sorted_entries[i])
					if (pos < 0 && sorted_entries[i] == v)
						pos = i;
				if (pos < 0) begin
					beats.push_back(make_beat(STAT_NOTFOUND, '0, 1'b1));
				end else begin
					sorted_entries.delete(pos);
					beats.push_back(make_beat(STAT_DONE, '0, 1'b1));
				end
			end
			KIND_CLEAR: begin
				sorted_entries.delete();
				beats.push_back(make_beat(STAT_DONE, '0, 1'b1));
			end
			KIND_READ: begin
				if (sorted_entries.size() == 0)
					beats.push_back(make_beat(STAT_EMPTY, '0, 1'b1));
				else
					foreach (sorted_entries[i])
						beats.push_back(make_beat(STAT_ELEM, sorted_entries[i],
							i == sorted_entries.size() - 1));
			end
			// count and the spare kinds
			default: beats.push_back(make_beat(STAT_DONE, '0, 1'b1));
		endcase
	endtask

	// random idle burst, none over the tail of the run
	task automatic maybe_idle();
		if (idle_on && items_accepted < DIRECTED_N + RANDOM_ITEMS - TAIL_ITEMS
				&& $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	// drive one beat and wait for acceptance; start stays high until the next call decides
	task automatic send_item(input item_t it, input bit has_typed, input result_t typed_beat);
		result_q_t beats;
		maybe_idle();
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy !== 1'b0);
		items_accepted++;
		compute_list_results(it, beats);
		if (has_typed)
			pending_beats.push_back(typed_beat);
		else
			foreach (beats[i])
				pending_beats.push_back(beats[i]);
	endtask

	task automatic issue(input logic [KIND_W-1:0] kind, input logic signed [IOVAL_W-1:0] v);
		item_t it;
		it.kind  = kind;
		it.value = v;
		send_item(it, 1'b0, '0);
	endtask

	task automatic wait_all_results();
		start <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	// extremes, a small pool for duplicates, stored values, full-range noise
	function automatic logic signed [IOVAL_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3, 4: return int'($urandom_range(0, 8)) - 4;
			5: begin
				if (sorted_entries.size() != 0)
					return sorted_entries[$urandom_range(0, sorted_entries.size() - 1)];
				return $urandom;
			end
			default: return $urandom;
		endcase
	endfunction

	// result checker: the receiver never stalls, so every strobe is a beat
	always @(posedge clk) begin
		if (arst_n && result_strobe === 1'b1) begin
			beat_no++;
			if (pending_beats.size() == 0) begin
				report_mismatch($sformatf("beat %0d arrived with nothing expected", beat_no));
			end else begin
				want = pending_beats.pop_front();
				if (result.status !== want.status)
					report_mismatch($sformatf("beat %0d status %0d, want %0d",
						beat_no, result.status, want.status));
				if (result.entry_value !== want.entry_value)
					report_mismatch($sformatf("beat %0d entry_value %0d, want %0d",
						beat_no, result.entry_value, want.entry_value));
				if (result.occupancy !== want.occupancy)
					report_mismatch($sformatf("beat %0d occupancy %0d, want %0d",
						beat_no, result.occupancy, want.occupancy));
				if (result.last !== want.last)
					report_mismatch($sformatf("beat %0d last %0b, want %0b",
						beat_no, result.last, want.last));
			end
		end
	end

	// watchdog on cycles with no beat in or out
	always @(posedge clk) begin
		if ((start && busy === 1'b0) || result_strobe === 1'b1) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		item_t   it;
		result_t typed_beat;
		int      episode;
		bit      first_episode;
		int      r;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (DIRECTED[i]) begin
			it.kind                = DIRECTED[i].kind;
			it.value               = DIRECTED[i].value;
			typed_beat.status      = DIRECTED[i].st;
			typed_beat.entry_value = '0;
			typed_beat.occupancy   = DIRECTED[i].occ;
			typed_beat.last        = 1'b1;
			send_item(it, DIRECTED[i].typed, typed_beat);
		end
		wait_all_results();

		// random episodes; the first one fills the list to reach the full case
		first_episode = 1'b1;
		while (items_accepted < DIRECTED_N + RANDOM_ITEMS) begin
			idle_on = $urandom_range(0, 2) != 0;
			episode = first_episode ? 0 : $urandom_range(0, 5);
			first_episode = 1'b0;
			case (episode)
				0: begin
					// fill, overfill, read out, then hold off until all beats are back
					while (sorted_entries.size() < CAPACITY)
						issue(KIND_INSERT, pick_value());
					repeat ($urandom_range(1, 3))
						issue(KIND_INSERT, pick_value());
					issue(KIND_READ, $urandom);
					wait_all_results();
				end
				1: begin
					// drain, mostly with hits
					while (sorted_entries.size() != 0) begin
						if ($urandom_range(0, 4) == 0)
							issue(KIND_DELETE, $urandom);
						else
							issue(KIND_DELETE, sorted_entries[$urandom_range(0,
								sorted_entries.size() - 1)]);
					end
					issue(KIND_DELETE, pick_value());
					issue(KIND_READ, $urandom);
				end
				2: begin
					issue(KIND_CLEAR, $urandom);
					issue(KIND_READ, $urandom);
					issue(KIND_COUNT, $urandom);
				end
				default: begin
					// mixed traffic
					repeat ($urandom_range(8, 20)) begin
						r = $urandom_range(0, 99);
						if (r < 40)
							issue(KIND_INSERT, pick_value());
						else if (r < 65)
							issue(KIND_DELETE, pick_value());
						else if (r < 75)
							issue(KIND_READ, $urandom);
						else if (r < 83)
							issue(KIND_COUNT, $urandom);
						else if (r < 88)
							issue(KIND_CLEAR, $urandom);
						else
							issue(KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)),
								$urandom);
					end
				end
			endcase
		end

		// wind down: no more beats, let any stray result show up
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_beats.size() != 0)
			report_mismatch($sformatf("%0d beats never arrived", pending_beats.size()));
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[sorted_list_insert_delete_unit.f]
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_ctrl.sv
rtl/sli_dp.sv
rtl/sorted_list_insert_delete_unit.sv
tb/tb.sv
